/* rtl/ftsu_pkg.sv */
// ----------------------------------------------------------------------------
// ftsu_pkg
// Shared widths, operation codes, series coefficients and saturating helpers
// for the fast trigonometry series unit.
// ----------------------------------------------------------------------------
package ftsu_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 27;
	localparam int ACC_W     = 64;
	localparam int Q_W       = FRAC_W + 1;
	localparam int REM_W     = DATA_W + 3;
	localparam int SH_W      = 7;
	localparam int MUL_LAT   = 5;
	localparam int N_SLOT    = 6;
	localparam int COEF_FRAC = 60;
	localparam int CQ_SH     = COEF_FRAC - FRAC_W;
	localparam int ANG_SH    = 62 - FRAC_W;

	localparam logic [2:0] OP_SIN   = 3'd0;
	localparam logic [2:0] OP_COS   = 3'd1;
	localparam logic [2:0] OP_TAN   = 3'd2;
	localparam logic [2:0] OP_ASIN  = 3'd3;
	localparam logic [2:0] OP_ATAN  = 3'd4;
	localparam logic [2:0] OP_ATAN2 = 3'd5;

	localparam logic signed [ACC_W-1:0] MAX64 = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] MIN64 = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] MAX_OUT = ACC_W'((64'd1 << (DATA_W - 1)) - 64'd1);
	localparam logic signed [ACC_W-1:0] MIN_OUT = -MAX_OUT - ACC_W'(1);

	localparam logic [63:0] Q60 = 64'd1 << COEF_FRAC;

	localparam logic [63:0] CR_1_2 = (Q60 / 64'd2) + ((Q60 % 64'd2) + 64'd1) / 64'd2;
	localparam logic [63:0] CR_1_3 = (Q60 / 64'd3) + ((Q60 % 64'd3) + 64'd1) / 64'd3;
	localparam logic [63:0] CR_1_5 = (Q60 / 64'd5) + ((Q60 % 64'd5) + 64'd2) / 64'd5;
	localparam logic [63:0] CR_1_6 = (Q60 / 64'd6) + ((Q60 % 64'd6) + 64'd3) / 64'd6;
	localparam logic [63:0] CR_1_7 = (Q60 / 64'd7) + ((Q60 % 64'd7) + 64'd3) / 64'd7;
	localparam logic [63:0] CR_1_9 = (Q60 / 64'd9) + ((Q60 % 64'd9) + 64'd4) / 64'd9;
	localparam logic [63:0] CR_1_24 =
		(Q60 / 64'd24) + ((Q60 % 64'd24) + 64'd12) / 64'd24;
	localparam logic [63:0] CR_1_120 =
		(Q60 / 64'd120) + ((Q60 % 64'd120) + 64'd60) / 64'd120;
	localparam logic [63:0] CR_1_720 =
		(Q60 / 64'd720) + ((Q60 % 64'd720) + 64'd360) / 64'd720;
	localparam logic [63:0] CR_1_40320 =
		(Q60 / 64'd40320) + ((Q60 % 64'd40320) + 64'd20160) / 64'd40320;
	localparam logic [63:0] CR_2_15 =
		(Q60 / 64'd15) * 64'd2 + ((Q60 % 64'd15) * 64'd2 + 64'd7) / 64'd15;
	localparam logic [63:0] CR_17_315 =
		(Q60 / 64'd315) * 64'd17 + ((Q60 % 64'd315) * 64'd17 + 64'd157) / 64'd315;
	localparam logic [63:0] CR_3_40 =
		(Q60 / 64'd40) * 64'd3 + ((Q60 % 64'd40) * 64'd3 + 64'd20) / 64'd40;
	localparam logic [63:0] CR_5_112 =
		(Q60 / 64'd112) * 64'd5 + ((Q60 % 64'd112) * 64'd5 + 64'd56) / 64'd112;
	localparam logic [63:0] CR_35_1152 =
		(Q60 / 64'd1152) * 64'd35 + ((Q60 % 64'd1152) * 64'd35 + 64'd576) / 64'd1152;
	localparam logic [63:0] CR_1963 =
		(Q60 / 64'd10000) * 64'd1963 + ((Q60 % 64'd10000) * 64'd1963 + 64'd5000) / 64'd10000;
	localparam logic [63:0] CR_9817 =
		(Q60 / 64'd10000) * 64'd9817 + ((Q60 % 64'd10000) * 64'd9817 + 64'd5000) / 64'd10000;

	localparam logic [63:0] PI4_Q62 = 64'h3243F6A8885A308D;
	localparam logic signed [ACC_W-1:0] ANG_1 =
		ACC_W'((PI4_Q62 + (64'd1 << (ANG_SH - 1))) >> ANG_SH);
	localparam logic signed [ACC_W-1:0] ANG_3 =
		ACC_W'((PI4_Q62 * 64'd3 + (64'd1 << (ANG_SH - 1))) >> ANG_SH);

	typedef struct packed {
		logic                    valid;
		logic [2:0]              op;
		logic                    sat;
		logic                    neg_y;
		logic                    neg_x;
		logic                    neg_num;
		logic signed [ACC_W-1:0] x;
		logic signed [ACC_W-1:0] x2;
		logic signed [ACC_W-1:0] acc;
		logic [REM_W-1:0]        rem;
		logic [REM_W-1:0]        den;
		logic [Q_W-1:0]          q;
	} pipe_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] a;
		logic signed [ACC_W-1:0] b;
		logic [SH_W-1:0]         sh;
	} mul_req_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] p;
		logic                    ovf;
	} mul_rsp_t;

	// coefficient from 60 fraction bits to the working format, half away from zero
	function automatic logic signed [ACC_W-1:0] cq(input logic [63:0] c);
		return ACC_W'((c + (64'd1 << (CQ_SH - 1))) >> CQ_SH);
	endfunction

	localparam logic signed [ACC_W-1:0] K_ATAN2_C1 = -cq(CR_9817);

	function automatic logic [2:0] series_len(input logic [2:0] op);
		case (op)
			OP_SIN:  return 3'd3;
			OP_TAN:  return 3'd4;
			default: return 3'd5;
		endcase
	endfunction

	function automatic logic signed [ACC_W-1:0] series_coef(input logic [2:0] op,
			input logic [2:0] k);
		logic signed [ACC_W-1:0] c;
		c = '0;
		case (op)
			OP_SIN: begin
				case (k)
					3'd0:    c = cq(Q60);
					3'd1:    c = -cq(CR_1_6);
					3'd2:    c = cq(CR_1_120);
					default: c = '0;
				endcase
			end
			OP_COS: begin
				case (k)
					3'd0:    c = cq(Q60);
					3'd1:    c = -cq(CR_1_2);
					3'd2:    c = cq(CR_1_24);
					3'd3:    c = -cq(CR_1_720);
					3'd4:    c = cq(CR_1_40320);
					default: c = '0;
				endcase
			end
			OP_TAN: begin
				case (k)
					3'd0:    c = cq(Q60);
					3'd1:    c = cq(CR_1_3);
					3'd2:    c = cq(CR_2_15);
					3'd3:    c = cq(CR_17_315);
					default: c = '0;
				endcase
			end
			OP_ASIN: begin
				case (k)
					3'd0:    c = cq(Q60);
					3'd1:    c = cq(CR_1_6);
					3'd2:    c = cq(CR_3_40);
					3'd3:    c = cq(CR_5_112);
					3'd4:    c = cq(CR_35_1152);
					default: c = '0;
				endcase
			end
			OP_ATAN: begin
				case (k)
					3'd0:    c = cq(Q60);
					3'd1:    c = -cq(CR_1_3);
					3'd2:    c = cq(CR_1_5);
					3'd3:    c = -cq(CR_1_7);
					3'd4:    c = cq(CR_1_9);
					default: c = '0;
				endcase
			end
			default: c = '0;
		endcase
		return c;
	endfunction

	// {overflow, sum} held at the limit of the operand sign
	function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W-1:0] s;
		logic                    o;
		s = a + b;
		o = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
		if (o) begin
			s = a[ACC_W-1] ? MIN64 : MAX64;
		end
		return {o, s};
	endfunction

endpackage

/* rtl/ftsu_cmd_if.sv */
// ----------------------------------------------------------------------------
// ftsu_cmd_if
// Request channel of the trig unit: operation and two operands.
// ----------------------------------------------------------------------------
interface ftsu_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [2:0]                      operation;
	logic signed [ftsu_pkg::DATA_W-1:0] operand_a;
	logic signed [ftsu_pkg::DATA_W-1:0] operand_b;

	modport source (output valid, output operation, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input operation, input operand_a, input operand_b,
		output ready);
endinterface

/* rtl/ftsu_res_if.sv */
// ----------------------------------------------------------------------------
// ftsu_res_if
// Result channel of the trig unit: value and saturation flag.
// ----------------------------------------------------------------------------
interface ftsu_res_if;
	logic                            valid;
	logic                            ready;
	logic signed [ftsu_pkg::DATA_W-1:0] result_value;
	logic                            saturated;

	modport source (output valid, output result_value, output saturated, input ready);
	modport sink (input valid, input result_value, input saturated, output ready);
endinterface

/* rtl/ftsu_mul.sv */
// ----------------------------------------------------------------------------
// ftsu_mul
// Five-stage signed 64x64 multiply with round half up, variable right shift
// and saturation to 64 bits, built from four 32x32 partial products.
// ----------------------------------------------------------------------------
module ftsu_mul (
	input  logic                clk,
	input  logic                en,
	input  ftsu_pkg::mul_req_t  req,
	output ftsu_pkg::mul_rsp_t  rsp
);

	logic                           neg_s1, neg_s2, neg_s3;
	logic [ftsu_pkg::ACC_W-1:0]     ma_s1, mb_s1;
	logic [ftsu_pkg::SH_W-1:0]      sh_s1, sh_s2, sh_s3, sh_s4;
	logic [63:0]                    p00_s2, p01_s2, p10_s2, p11_s2;
	logic [127:0]                   m_s3;
	logic [127:0]                   t_s4;
	logic [127:0]                   half;
	logic signed [127:0]            shr;
	logic                           ovf;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= req.a[ftsu_pkg::ACC_W-1] ^ req.b[ftsu_pkg::ACC_W-1];
			ma_s1  <= req.a[ftsu_pkg::ACC_W-1] ? -req.a : req.a;
			mb_s1  <= req.b[ftsu_pkg::ACC_W-1] ? -req.b : req.b;
			sh_s1  <= req.sh;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s2 <= ma_s1[31:0]  * mb_s1[31:0];
			p01_s2 <= ma_s1[31:0]  * mb_s1[63:32];
			p10_s2 <= ma_s1[63:32] * mb_s1[31:0];
			p11_s2 <= ma_s1[63:32] * mb_s1[63:32];
			neg_s2 <= neg_s1;
			sh_s2  <= sh_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3   <= {64'd0, p00_s2} + {32'd0, p01_s2, 32'd0} + {32'd0, p10_s2, 32'd0}
				+ {p11_s2, 64'd0};
			neg_s3 <= neg_s2;
			sh_s3  <= sh_s2;
		end
	end

	assign half = 128'd1 << (sh_s3 - 7'd1);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4  <= neg_s3 ? (~m_s3 + half + 128'd1) : (m_s3 + half);
			sh_s4 <= sh_s3;
		end
	end

	always_comb begin
		shr = $signed(t_s4) >>> sh_s4;
		ovf = (shr[127:63] != '0) && (shr[127:63] != '1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.ovf <= ovf;
			rsp.p   <= ovf ? (t_s4[127] ? ftsu_pkg::MIN64 : ftsu_pkg::MAX64) : shr[63:0];
		end
	end

endmodule

/* rtl/fast_trig_series_unit_top.sv */
// ----------------------------------------------------------------------------
// fast_trig_series_unit_top
// Stages: entry, prep, 28 divider steps, selection, six multiply slots of six
// stages each, negate, output clamp.
// Throughput: one request per cycle; the whole pipeline holds on a stalled result.
// Reset: arst_n clears every valid bit at once; no clearing pass.
// ----------------------------------------------------------------------------
module fast_trig_series_unit_top (
	input  logic       clk,
	input  logic       arst_n,
	ftsu_cmd_if.sink   cmd,
	ftsu_res_if.source res
);

	localparam int AW = ftsu_pkg::ACC_W;
	localparam int DW = ftsu_pkg::DATA_W;
	localparam int RW = ftsu_pkg::REM_W;
	localparam int QW = ftsu_pkg::Q_W;
	localparam int NS = ftsu_pkg::N_SLOT;

	logic                     en;
	logic                     valid_s1;
	logic [2:0]               op_s1;
	logic signed [DW-1:0]     a_s1, b_s1;
	ftsu_pkg::pipe_t          prep, prep_s2;
	ftsu_pkg::pipe_t          div_w [QW+1];
	ftsu_pkg::pipe_t          sel, sel_s;
	ftsu_pkg::pipe_t          slot_w [NS+1];
	ftsu_pkg::pipe_t          neg, neg_s;
	logic                     res_valid_q, res_sat_q;
	logic signed [DW-1:0]     res_value_q;

	assign en        = !res_valid_q || res.ready;
	assign cmd.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1    <= '0;
			a_s1     <= '0;
			b_s1     <= '0;
		end else if (en) begin
			valid_s1 <= cmd.valid;
			op_s1    <= cmd.operation;
			a_s1     <= cmd.operand_a;
			b_s1     <= cmd.operand_b;
		end
	end

	// atan2 numerator and divisor, series start value
	always_comb begin
		logic signed [RW-1:0] ax, bx, ay, num, den;
		ax = {{(RW-DW){a_s1[DW-1]}}, a_s1};
		bx = {{(RW-DW){b_s1[DW-1]}}, b_s1};
		ay = (ax < 0 ? -ax : ax) + RW'(1);
		if (bx < 0) begin
			num = bx + ay;
			den = ay - bx;
		end else begin
			num = bx - ay;
			den = bx + ay;
		end
		prep         = '0;
		prep.valid   = valid_s1;
		prep.op      = op_s1;
		prep.neg_y   = a_s1[DW-1];
		prep.neg_x   = b_s1[DW-1];
		prep.neg_num = num[RW-1];
		prep.x       = {{(AW-DW){a_s1[DW-1]}}, a_s1};
		prep.acc     = ftsu_pkg::series_coef(op_s1, ftsu_pkg::series_len(op_s1) - 3'd1);
		prep.rem     = num[RW-1] ? -num : num;
		prep.den     = den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_s2 <= '0;
		end else if (en) begin
			prep_s2 <= prep;
		end
	end

	assign div_w[0] = prep_s2;

	// restoring divider, one quotient bit per stage
	for (genvar i = 0; i < QW; i++) begin : g_div
		ftsu_pkg::pipe_t nxt, div_s;
		always_comb begin
			logic [RW-1:0] r;
			logic          ge;
			r   = (i == 0) ? div_w[i].rem : {div_w[i].rem[RW-2:0], 1'b0};
			ge  = r >= div_w[i].den;
			nxt = div_w[i];
			nxt.rem = ge ? r - div_w[i].den : r;
			nxt.q   = {div_w[i].q[QW-2:0], ge};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s <= '0;
			end else if (en) begin
				div_s <= nxt;
			end
		end
		assign div_w[i+1] = div_s;
	end

	always_comb begin
		logic signed [AW-1:0] qx;
		qx  = {{(AW-QW){1'b0}}, div_w[QW].q};
		sel = div_w[QW];
		if (div_w[QW].op == ftsu_pkg::OP_ATAN2) begin
			sel.x = div_w[QW].neg_num ? -qx : qx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_s <= '0;
		end else if (en) begin
			sel_s <= sel;
		end
	end

	assign slot_w[0] = sel_s;

	// multiply slots: square, four horner steps, final odd factor or angle add
	for (genvar j = 0; j < NS; j++) begin : g_slot
		ftsu_pkg::mul_req_t req;
		ftsu_pkg::mul_rsp_t rsp;
		ftsu_pkg::pipe_t    dly_s [ftsu_pkg::MUL_LAT];
		ftsu_pkg::pipe_t    nxt, add_s;

		always_comb begin
			req.a  = slot_w[j].acc;
			req.b  = slot_w[j].x;
			req.sh = ftsu_pkg::SH_W'(ftsu_pkg::FRAC_W);
			if (j == 0) begin
				req.a = slot_w[j].x;
			end else if (j < NS - 1) begin
				if (slot_w[j].op == ftsu_pkg::OP_ATAN2) begin
					req.a  = slot_w[j].x2;
					req.b  = ftsu_pkg::CR_1963;
					req.sh = ftsu_pkg::SH_W'(ftsu_pkg::COEF_FRAC);
				end else begin
					req.b = slot_w[j].x2;
				end
			end
		end

		ftsu_mul u_mul (
			.clk (clk),
			.en  (en),
			.req (req),
			.rsp (rsp)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int k = 0; k < ftsu_pkg::MUL_LAT; k++) begin
					dly_s[k] <= '0;
				end
			end else if (en) begin
				dly_s[0] <= slot_w[j];
				for (int k = 1; k < ftsu_pkg::MUL_LAT; k++) begin
					dly_s[k] <= dly_s[k-1];
				end
			end
		end

		always_comb begin
			ftsu_pkg::pipe_t      d;
			logic                 act;
			logic signed [AW-1:0] addend;
			logic [AW:0]          sa;
			d      = dly_s[ftsu_pkg::MUL_LAT-1];
			nxt    = d;
			act    = 1'b0;
			addend = '0;
			sa     = '0;
			if (j == 0) begin
				nxt.x2  = rsp.p;
				nxt.sat = d.sat | rsp.ovf;
			end else if (j < NS - 1) begin
				if (d.op == ftsu_pkg::OP_ATAN2) begin
					act    = (j == 1);
					addend = ftsu_pkg::K_ATAN2_C1;
				end else begin
					act    = (d.op <= ftsu_pkg::OP_ATAN) &&
						(j >= NS - int'(ftsu_pkg::series_len(d.op)));
					addend = ftsu_pkg::series_coef(d.op, 3'(NS - 2 - j));
				end
				sa = ftsu_pkg::sat_add(rsp.p, addend);
				if (act) begin
					nxt.acc = sa[AW-1:0];
					nxt.sat = d.sat | rsp.ovf | sa[AW];
				end
			end else begin
				sa = ftsu_pkg::sat_add(d.neg_x ? ftsu_pkg::ANG_3 : ftsu_pkg::ANG_1, rsp.p);
				if (d.op == ftsu_pkg::OP_ATAN2) begin
					nxt.acc = sa[AW-1:0];
					nxt.sat = d.sat | rsp.ovf | sa[AW];
				end else if (d.op <= ftsu_pkg::OP_ATAN && d.op != ftsu_pkg::OP_COS) begin
					nxt.acc = rsp.p;
					nxt.sat = d.sat | rsp.ovf;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				add_s <= '0;
			end else if (en) begin
				add_s <= nxt;
			end
		end

		assign slot_w[j+1] = add_s;
	end

	// atan2 angle sign follows y
	always_comb begin
		neg = slot_w[NS];
		if (slot_w[NS].op == ftsu_pkg::OP_ATAN2 && slot_w[NS].neg_y) begin
			if (slot_w[NS].acc == ftsu_pkg::MIN64) begin
				neg.acc = ftsu_pkg::MAX64;
				neg.sat = 1'b1;
			end else begin
				neg.acc = -slot_w[NS].acc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_s <= '0;
		end else if (en) begin
			neg_s <= neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_value_q <= '0;
			res_sat_q   <= 1'b0;
		end else if (en) begin
			res_valid_q <= neg_s.valid;
			if (neg_s.op > ftsu_pkg::OP_ATAN2) begin
				res_value_q <= '0;
				res_sat_q   <= 1'b0;
			end else if (neg_s.acc > ftsu_pkg::MAX_OUT) begin
				res_value_q <= ftsu_pkg::MAX_OUT[DW-1:0];
				res_sat_q   <= 1'b1;
			end else if (neg_s.acc < ftsu_pkg::MIN_OUT) begin
				res_value_q <= ftsu_pkg::MIN_OUT[DW-1:0];
				res_sat_q   <= 1'b1;
			end else begin
				res_value_q <= neg_s.acc[DW-1:0];
				res_sat_q   <= neg_s.sat;
			end
		end
	end

	assign res.valid        = res_valid_q;
	assign res.result_value = res_value_q;
	assign res.saturated    = res_sat_q;

endmodule

/* rtl/ftsu_checker.sv */
// ----------------------------------------------------------------------------
// ftsu_checker
// Port-level checks on the trig unit: result hold under stall and the
// coupling of request ready to the result side.
// ----------------------------------------------------------------------------
module ftsu_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cmd_ready,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic signed [ftsu_pkg::DATA_W-1:0] result_value,
	input logic                            saturated
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(result_value) && $stable(saturated))
		else $error("result changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> cmd_ready)
		else $error("request refused with empty output");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !cmd_ready)
		else $error("request taken while pipeline held");

endmodule

bind fast_trig_series_unit_top ftsu_checker u_ftsu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_ready    (cmd.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.result_value (res.result_value),
	.saturated    (res.saturated)
);

/* tb/ftsu_trig_checker.sv */
// ----------------------------------------------------------------------------
// ftsu_trig_checker
// Watches the request and result channels of the trig unit. For every accepted
// request it computes the expected value and saturation flag with its own
// 64-bit saturating fixed-point arithmetic and queues them in order. Every
// accepted result is compared with the oldest queued entry.
// ----------------------------------------------------------------------------
module ftsu_trig_checker (
	input  logic clk,
	input  logic arst_n,
	ftsu_cmd_if  cmd,
	ftsu_res_if  res,
	output int   errors,
	output int   outstanding,
	output int   checked,
	output int   sat_seen
);

	typedef logic signed [63:0] w64_t;

	typedef struct packed {
		logic signed [ftsu_pkg::DATA_W-1:0] value;
		logic                               sat;
	} trig_result_t;

	localparam w64_t W_MAX = {1'b0, {63{1'b1}}};
	localparam w64_t W_MIN = {1'b1, {63{1'b0}}};
	localparam logic [63:0] PI_Q62 = 64'h3243F6A8885A308D;

	trig_result_t expected_results[$];
	logic         ovf;

	function automatic w64_t add_s(w64_t a, w64_t b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(W_MAX)) begin
			ovf = 1'b1;
			return W_MAX;
		end
		if (s < 65'(W_MIN)) begin
			ovf = 1'b1;
			return W_MIN;
		end
		return s[63:0];
	endfunction

	function automatic w64_t neg_s(w64_t a);
		if (a == W_MIN) begin
			ovf = 1'b1;
			return W_MAX;
		end
		return -a;
	endfunction

	// product scaled down by 2^s, half up, saturated
	function automatic w64_t mul_sh(w64_t a, w64_t b, int s);
		logic signed [127:0] la, lb, p;
		la = a;
		lb = b;
		p = la * lb;
		p = p + (128'sd1 <<< (s - 1));
		p = p >>> s;
		if (p > 128'(W_MAX) || p < 128'(W_MIN)) begin
			ovf = 1'b1;
			return p[127] ? W_MIN : W_MAX;
		end
		return p[63:0];
	endfunction

	function automatic logic [63:0] ratio_q60(logic [63:0] n, logic [63:0] d);
		logic [63:0] one;
		one = 64'd1 << 60;
		return (one / d) * n + ((one % d) * n + d / 2) / d;
	endfunction

	// 60-fraction-bit constant to working format, half away from zero
	function automatic w64_t to_work(w64_t c);
		logic [63:0] m;
		m = c[63] ? -c : c;
		m = (m + (64'd1 << (ftsu_pkg::COEF_FRAC - ftsu_pkg::FRAC_W - 1)))
			>> (ftsu_pkg::COEF_FRAC - ftsu_pkg::FRAC_W);
		return c[63] ? -w64_t'(m) : w64_t'(m);
	endfunction

	function automatic w64_t series_term(logic [2:0] op, int k);
		w64_t c;
		c = '0;
		case (op)
			ftsu_pkg::OP_SIN:
				case (k)
					0: c = ratio_q60(1, 1);
					1: c = -ratio_q60(1, 6);
					2: c = ratio_q60(1, 120);
					default: c = '0;
				endcase
			ftsu_pkg::OP_COS:
				case (k)
					0: c = ratio_q60(1, 1);
					1: c = -ratio_q60(1, 2);
					2: c = ratio_q60(1, 24);
					3: c = -ratio_q60(1, 720);
					4: c = ratio_q60(1, 40320);
					default: c = '0;
				endcase
			ftsu_pkg::OP_TAN:
				case (k)
					0: c = ratio_q60(1, 1);
					1: c = ratio_q60(1, 3);
					2: c = ratio_q60(2, 15);
					3: c = ratio_q60(17, 315);
					default: c = '0;
				endcase
			ftsu_pkg::OP_ASIN:
				case (k)
					0: c = ratio_q60(1, 1);
					1: c = ratio_q60(1, 6);
					2: c = ratio_q60(3, 40);
					3: c = ratio_q60(5, 112);
					4: c = ratio_q60(35, 1152);
					default: c = '0;
				endcase
			default:
				case (k)
					0: c = ratio_q60(1, 1);
					1: c = -ratio_q60(1, 3);
					2: c = ratio_q60(1, 5);
					3: c = -ratio_q60(1, 7);
					4: c = ratio_q60(1, 9);
					default: c = '0;
				endcase
		endcase
		return to_work(c);
	endfunction

	function automatic w64_t horner(logic [2:0] op, w64_t x);
		w64_t x2, acc;
		int   n;
		n = (op == ftsu_pkg::OP_SIN) ? 3 : (op == ftsu_pkg::OP_TAN) ? 4 : 5;
		x2 = mul_sh(x, x, ftsu_pkg::FRAC_W);
		acc = series_term(op, n - 1);
		for (int k = n - 2; k >= 0; k--) begin
			acc = add_s(mul_sh(acc, x2, ftsu_pkg::FRAC_W), series_term(op, k));
		end
		return (op == ftsu_pkg::OP_COS) ? acc : mul_sh(acc, x, ftsu_pkg::FRAC_W);
	endfunction

	function automatic w64_t octant_angle(w64_t y, w64_t x);
		w64_t        ay, num, den, ang, r, t;
		logic [63:0] rem, d, q;
		ay = add_s(y[63] ? neg_s(y) : y, 1);
		if (x[63]) begin
			num = add_s(x, ay);
			den = add_s(ay, neg_s(x));
			ang = w64_t'((PI_Q62 * 3 + (64'd1 << (ftsu_pkg::ANG_SH - 1)))
				>> ftsu_pkg::ANG_SH);
		end else begin
			num = add_s(x, neg_s(ay));
			den = add_s(x, ay);
			ang = w64_t'((PI_Q62 + (64'd1 << (ftsu_pkg::ANG_SH - 1))) >> ftsu_pkg::ANG_SH);
		end
		d = den;
		rem = num[63] ? -num : num;
		q = 0;
		if (rem >= d) begin
			q = 1;
			rem = rem - d;
		end
		for (int i = 0; i < ftsu_pkg::FRAC_W; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= d) begin
				rem = rem - d;
				q[0] = 1'b1;
			end
		end
		r = num[63] ? -w64_t'(q) : w64_t'(q);
		t = add_s(mul_sh(mul_sh(r, r, ftsu_pkg::FRAC_W), ratio_q60(1963, 10000), 60),
			to_work(-w64_t'(ratio_q60(9817, 10000))));
		ang = add_s(ang, mul_sh(t, r, ftsu_pkg::FRAC_W));
		return y[63] ? neg_s(ang) : ang;
	endfunction

	function automatic trig_result_t trig_eval(logic [2:0] op, w64_t a, w64_t b);
		trig_result_t o;
		w64_t         v;
		ovf = 1'b0;
		case (op)
			ftsu_pkg::OP_SIN, ftsu_pkg::OP_COS, ftsu_pkg::OP_TAN, ftsu_pkg::OP_ASIN,
			ftsu_pkg::OP_ATAN: v = horner(op, a);
			ftsu_pkg::OP_ATAN2: v = octant_angle(a, b);
			default: v = '0;
		endcase
		if (v > ftsu_pkg::MAX_OUT) begin
			v = ftsu_pkg::MAX_OUT;
			ovf = 1'b1;
		end
		if (v < ftsu_pkg::MIN_OUT) begin
			v = ftsu_pkg::MIN_OUT;
			ovf = 1'b1;
		end
		o.value = v[ftsu_pkg::DATA_W-1:0];
		o.sat = ovf;
		return o;
	endfunction

	assign outstanding = expected_results.size();

	initial begin
		errors = 0;
		checked = 0;
		sat_seen = 0;
	end

	always @(posedge clk) begin
		trig_result_t w;
		int           e;
		e = 0;
		if (arst_n) begin
			if (cmd.valid && cmd.ready) begin
				expected_results.push_back(trig_eval(cmd.operation, w64_t'(cmd.operand_a),
					w64_t'(cmd.operand_b)));
			end
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result value=%0d saturated=%0b",
						res.result_value, res.saturated);
					e++;
				end else begin
					w = expected_results.pop_front();
					checked <= checked + 1;
					if (w.sat) begin
						sat_seen <= sat_seen + 1;
					end
					if (res.result_value !== w.value) begin
						$error("result_value expected %0d actual %0d", w.value,
							res.result_value);
						e++;
					end
					if (res.saturated !== w.sat) begin
						$error("saturated expected %0b actual %0b", w.sat, res.saturated);
						e++;
					end
				end
			end
			if (e != 0) begin
				errors <= errors + e;
			end
		end
	end

endmodule

/* tb/tb_fast_trig_series_unit_top.sv */
// ----------------------------------------------------------------------------
// tb_fast_trig_series_unit_top
// Drives directed and random trig requests (all operations, unused codes,
// argument extremes, atan2 quadrants and zero inputs) with random gaps on the
// request side and random stalls on the result side; a checker beside the
// unit predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_fast_trig_series_unit_top;

	localparam int         DW           = ftsu_pkg::DATA_W;
	localparam logic [2:0] OP_UNUSED_LO = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;
	localparam int         N_RANDOM     = 1330;
	localparam int         IDLE_LIMIT   = 5000;
	localparam int         ONE_Q        = 1 << ftsu_pkg::FRAC_W;

	logic clk;
	logic arst_n;
	int   errors, outstanding, checked, sat_seen;
	int   sent;
	int   idle_cycles;
	int   op_count [8];
	bit   hold_ready_high;

	ftsu_cmd_if cmd_ch ();
	ftsu_res_if res_ch ();

	fast_trig_series_unit_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	ftsu_trig_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.errors(errors),
		.outstanding(outstanding),
		.checked(checked),
		.sat_seen(sat_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 60) begin
			return 0;
		end else if ($urandom_range(0, 99) < 85) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 40);
	endfunction

	function automatic logic signed [DW-1:0] rand_arg();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return DW'($urandom_range(0, 2 * ONE_Q)) - ONE_Q;
			2: return DW'($urandom_range(0, 4 * ONE_Q)) - 2 * ONE_Q;
			default: return DW'($urandom_range(0, 1 << 21)) - (1 << 20);
		endcase
	endfunction

	task automatic send(logic [2:0] op, logic signed [DW-1:0] a,
			logic signed [DW-1:0] b, bit with_gap);
		bit hit;
		int g;
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.operand_a <= a;
		cmd_ch.operand_b <= b;
		do begin
			@(negedge clk);
			hit = cmd_ch.ready;
			@(posedge clk);
		end while (!hit);
		sent++;
		op_count[op]++;
		g = with_gap ? gap_len() : 0;
		if (g > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// result side stalls; some stretches keep ready high throughout
	initial begin
		res_ch.ready = 1'b0;
		hold_ready_high = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0) begin
				hold_ready_high = !hold_ready_high;
			end
			if (hold_ready_high || $urandom_range(0, 99) < 70) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (arst_n && (cmd_ch.valid || outstanding != 0)) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [2:0] op;
		sent = 0;
		idle_cycles = 0;
		foreach (op_count[i]) op_count[i] = 0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = ftsu_pkg::OP_SIN;
		cmd_ch.operand_a = '0;
		cmd_ch.operand_b = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes and special cases
		send(ftsu_pkg::OP_SIN, 32'sh7fffffff, 32'sh7fffffff, 0);
		send(ftsu_pkg::OP_SIN, 32'sh80000000, 32'sh80000000, 0);
		send(ftsu_pkg::OP_COS, '0, '0, 0);
		send(ftsu_pkg::OP_COS, 32'sh7fffffff, '0, 1);
		send(ftsu_pkg::OP_TAN, ONE_Q, -1, 0);
		send(ftsu_pkg::OP_TAN, 32'sh80000000, '0, 0);
		send(ftsu_pkg::OP_ASIN, -ONE_Q, '0, 1);
		send(ftsu_pkg::OP_ASIN, 32'sh7fffffff, '0, 0);
		send(ftsu_pkg::OP_ATAN, ONE_Q / 2, '0, 0);
		send(ftsu_pkg::OP_ATAN, 32'sh80000000, '0, 1);
		send(ftsu_pkg::OP_ATAN2, '0, '0, 0);
		send(ftsu_pkg::OP_ATAN2, ONE_Q, -ONE_Q, 0);
		send(ftsu_pkg::OP_ATAN2, -ONE_Q, ONE_Q, 0);
		send(ftsu_pkg::OP_ATAN2, -ONE_Q, -ONE_Q, 1);
		send(ftsu_pkg::OP_ATAN2, 32'sh80000000, 32'sh80000000, 0);
		send(ftsu_pkg::OP_ATAN2, 32'sh7fffffff, 32'sh7fffffff, 0);
		send(ftsu_pkg::OP_ATAN2, 32'sh80000000, 32'sh7fffffff, 0);
		send(ftsu_pkg::OP_ATAN2, '0, -1, 1);
		send(OP_UNUSED_LO, 32'sh7fffffff, -1, 0);
		send(OP_UNUSED_HI, 32'sh80000000, '0, 1);

		for (int n = 0; n < N_RANDOM; n++) begin
			if ($urandom_range(0, 99) < 4) begin
				op = $urandom_range(OP_UNUSED_LO, OP_UNUSED_HI);
			end else begin
				op = $urandom_range(ftsu_pkg::OP_SIN, ftsu_pkg::OP_ATAN2);
			end
			send(op, rand_arg(), rand_arg(), $urandom_range(0, 3) != 0);
		end
		cmd_ch.valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("sent %0d requests: sin %0d cos %0d tan %0d asin %0d atan %0d atan2 %0d",
			sent, op_count[ftsu_pkg::OP_SIN], op_count[ftsu_pkg::OP_COS],
			op_count[ftsu_pkg::OP_TAN], op_count[ftsu_pkg::OP_ASIN],
			op_count[ftsu_pkg::OP_ATAN], op_count[ftsu_pkg::OP_ATAN2]);
		$display("unused codes %0d, results checked %0d, saturated results %0d",
			op_count[OP_UNUSED_LO] + op_count[OP_UNUSED_HI], checked, sat_seen);
		if (errors == 0 && checked == sent) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
